### design/sba_pkg.sv
// Shared types and constants for the sector bitmap allocator.
package sba_pkg;

  // Request codes; codes five to seven are unused and fail.
  typedef enum logic [2:0] {
    REQ_QUERY  = 3'd0,
    REQ_ALLOC  = 3'd1,
    REQ_FREE   = 3'd2,
    REQ_NEXT   = 3'd3,
    REQ_FORMAT = 3'd4
  } req_e;

  // Sectors held back on the reserved track after a format.
  localparam logic [3:0] RSV_MASK = 4'hF;
  localparam int unsigned RSV_USED = 4;

  // Field widths of the request and result ports.
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned TRK_W  = 8;
  localparam int unsigned SEC_W  = 8;
  localparam int unsigned GT_W   = 7;
  localparam int unsigned GS_W   = 6;
  localparam int unsigned TOT_W  = 12;

  // Control from the sequencer to the bitmap memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_req_t;

endpackage

### design/sba_map_mem.sv
// Bitmap memory: one row of free bits per track, with per-row valid bits.
module sba_map_mem #(
  parameter int unsigned NUM_TRACKS      = 80,
  parameter int unsigned SECTORS_PER_TRK = 40,
  parameter int unsigned RESERVED_TRACK  = 40,
  parameter int unsigned TW              = $clog2(NUM_TRACKS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sba_pkg::mem_req_t           req_i,
  input  logic [TW-1:0]               rd_addr_i,
  input  logic [TW-1:0]               wr_addr_i,
  input  logic [SECTORS_PER_TRK-1:0]  wr_row_i,
  output logic [SECTORS_PER_TRK-1:0]  rd_row_o
);

  localparam logic [SECTORS_PER_TRK-1:0] ROW_ONES = '1;
  localparam logic [SECTORS_PER_TRK-1:0] ROW_RSV  =
    {{(SECTORS_PER_TRK-4){1'b0}}, sba_pkg::RSV_MASK};

  logic [SECTORS_PER_TRK-1:0] mem [NUM_TRACKS];
  logic [NUM_TRACKS-1:0]      vld_q;
  logic [SECTORS_PER_TRK-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic [TW-1:0]              rd_idx_q;
  logic                       rd_is_rsv;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
      rd_idx_q  <= rd_addr_i;
    end
  end

  // A row not written since reset or format reads as its formatted contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_is_rsv = ({1'b0, 8'(rd_idx_q)} + 9'd1) == 9'(RESERVED_TRACK);
  assign rd_row_o  = rd_vld_q ? rd_data_q
                              : (rd_is_rsv ? (ROW_ONES & ~ROW_RSV) : ROW_ONES);

endmodule

### design/sba_ctrl.sv
// Request sequencer: decode, read-modify-write, next-free search, result register.
module sba_ctrl #(
  parameter int unsigned NUM_TRACKS      = 80,
  parameter int unsigned SECTORS_PER_TRK = 40,
  parameter int unsigned RESERVED_TRACK  = 40,
  parameter int unsigned TW              = $clog2(NUM_TRACKS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sba_pkg::REQ_W-1:0]     req_type_i,
  input  logic [sba_pkg::TRK_W-1:0]     track_i,
  input  logic [sba_pkg::SEC_W-1:0]     sector_i,
  input  logic [sba_pkg::TRK_W-1:0]     near_track_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [sba_pkg::GT_W-1:0]      got_track_o,
  output logic [sba_pkg::GS_W-1:0]      got_sector_o,
  output logic [sba_pkg::TOT_W-1:0]     free_total_o,
  output sba_pkg::mem_req_t             mem_req_o,
  output logic [TW-1:0]                 rd_addr_o,
  output logic [TW-1:0]                 wr_addr_o,
  output logic [SECTORS_PER_TRK-1:0]    wr_row_o,
  input  logic [SECTORS_PER_TRK-1:0]    rd_row_i
);

  localparam int unsigned SW = $clog2(SECTORS_PER_TRK);
  localparam int unsigned RES_ON =
    (RESERVED_TRACK >= 1 && RESERVED_TRACK <= NUM_TRACKS) ? 1 : 0;
  localparam int unsigned FMT_TOTAL =
    (NUM_TRACKS * SECTORS_PER_TRK - RES_ON * sba_pkg::RSV_USED) % 4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SEARCH,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic [sba_pkg::REQ_W-1:0]   req_q, req_d;
  logic [sba_pkg::TRK_W-1:0]   trk_q, trk_d;
  logic [SW-1:0]               sec_q, sec_d;
  logic [sba_pkg::TRK_W-1:0]   start_q, start_d;
  logic [sba_pkg::TRK_W-1:0]   dist_q, dist_d;
  logic                        dir_q, dir_d;
  logic                        pend_q, pend_d;
  logic [sba_pkg::TRK_W-1:0]   pend_trk_q, pend_trk_d;
  logic                        gen_done_q, gen_done_d;
  logic [sba_pkg::TOT_W-1:0]   total_q, total_d;
  logic                        res_ok_q, res_ok_d;
  logic [sba_pkg::GT_W-1:0]    res_gt_q, res_gt_d;
  logic [sba_pkg::GS_W-1:0]    res_gs_q, res_gs_d;
  logic                        out_valid_q;
  logic                        out_ok_q;
  logic [sba_pkg::GT_W-1:0]    out_gt_q;
  logic [sba_pkg::GS_W-1:0]    out_gs_q;
  logic [sba_pkg::TOT_W-1:0]   out_total_q;

  logic                        accept;
  logic                        load_out;
  logic                        loc_ok;
  logic                        cur_bit;
  logic [SECTORS_PER_TRK-1:0]  sec_onehot;
  logic [9:0]                  cand;
  logic                        cand_ok;
  logic                        row_hit;
  logic [SW-1:0]               low_idx;
  logic [SECTORS_PER_TRK-1:0]  low_onehot;

  // Lowest set bit of a row.
  function automatic logic [SW-1:0] lowest_set(input logic [SECTORS_PER_TRK-1:0] row);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = SECTORS_PER_TRK - 1; i >= 0; i--) begin
      if (row[i]) begin
        idx = SW'(i);
      end
    end
    return idx;
  endfunction

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign loc_ok   = (track_i != '0) && ({1'b0, track_i} <= 9'(NUM_TRACKS)) &&
                    ({1'b0, sector_i} < 9'(SECTORS_PER_TRK));

  assign sec_onehot = SECTORS_PER_TRK'(1) << sec_q;
  assign cur_bit    = rd_row_i[sec_q];

  // Candidate track for the current search distance and direction.
  assign cand    = dir_q ? ({2'b00, start_q} - {2'b00, dist_q})
                         : ({2'b00, start_q} + {2'b00, dist_q});
  assign cand_ok = !cand[9] && (cand != '0) && (cand <= 10'(NUM_TRACKS)) &&
                   (cand != 10'(RESERVED_TRACK));

  assign row_hit    = pend_q && (rd_row_i != '0);
  assign low_idx    = lowest_set(rd_row_i);
  assign low_onehot = SECTORS_PER_TRK'(1) << low_idx;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    trk_d      = trk_q;
    sec_d      = sec_q;
    start_d    = start_q;
    dist_d     = dist_q;
    dir_d      = dir_q;
    pend_d     = pend_q;
    pend_trk_d = pend_trk_q;
    gen_done_d = gen_done_q;
    total_d    = total_q;
    res_ok_d   = res_ok_q;
    res_gt_d   = res_gt_q;
    res_gs_d   = res_gs_q;
    mem_req_o  = '0;
    rd_addr_o  = TW'(trk_q - 8'd1);
    wr_addr_o  = TW'(trk_q - 8'd1);
    wr_row_o   = rd_row_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = req_type_i;
          trk_d    = track_i;
          sec_d    = SW'(sector_i);
          res_ok_d = 1'b0;
          res_gt_d = '0;
          res_gs_d = '0;
          state_d  = S_RESP;
          case (req_type_i)
            sba_pkg::REQ_QUERY, sba_pkg::REQ_ALLOC, sba_pkg::REQ_FREE: begin
              if (loc_ok) begin
                state_d = S_READ;
              end
            end
            sba_pkg::REQ_NEXT: begin
              start_d    = (near_track_i == '0) ? 8'(RESERVED_TRACK) : near_track_i;
              dist_d     = '0;
              dir_d      = 1'b0;
              pend_d     = 1'b0;
              gen_done_d = 1'b0;
              state_d    = S_SEARCH;
            end
            sba_pkg::REQ_FORMAT: begin
              mem_req_o.clr = 1'b1;
              total_d       = sba_pkg::TOT_W'(FMT_TOTAL);
              res_ok_d      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        mem_req_o.rd_en = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_RESP;
        case (req_q)
          sba_pkg::REQ_QUERY: begin
            res_ok_d = cur_bit;
          end
          sba_pkg::REQ_ALLOC: begin
            if (cur_bit) begin
              mem_req_o.wr_en = 1'b1;
              wr_row_o        = rd_row_i & ~sec_onehot;
              total_d         = total_q - 1'b1;
              res_ok_d        = 1'b1;
            end
          end
          sba_pkg::REQ_FREE: begin
            if (!cur_bit) begin
              mem_req_o.wr_en = 1'b1;
              wr_row_o        = rd_row_i | sec_onehot;
              total_d         = total_q + 1'b1;
              res_ok_d        = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        if (row_hit) begin
          // Claim the lowest free sector of the first track that has one.
          mem_req_o.wr_en = 1'b1;
          wr_addr_o       = TW'(pend_trk_q - 8'd1);
          wr_row_o        = rd_row_i & ~low_onehot;
          total_d         = total_q - 1'b1;
          res_ok_d        = 1'b1;
          res_gt_d        = sba_pkg::GT_W'(pend_trk_q);
          res_gs_d        = sba_pkg::GS_W'(low_idx);
          state_d         = S_RESP;
        end else if (gen_done_q) begin
          state_d = S_RESP;
        end else begin
          pend_d     = cand_ok;
          pend_trk_d = cand[7:0];
          if (cand_ok) begin
            mem_req_o.rd_en = 1'b1;
            rd_addr_o       = TW'(cand[7:0] - 8'd1);
          end
          if (dir_q) begin
            dir_d      = 1'b0;
            dist_d     = dist_q + 1'b1;
            gen_done_d = (dist_q == 8'(NUM_TRACKS - 1));
          end else begin
            dir_d = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dist_q      <= '0;
      dir_q       <= 1'b0;
      pend_q      <= 1'b0;
      gen_done_q  <= 1'b0;
      total_q     <= sba_pkg::TOT_W'(FMT_TOTAL);
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      dist_q     <= dist_d;
      dir_q      <= dir_d;
      pend_q     <= pend_d;
      gen_done_q <= gen_done_d;
      total_q    <= total_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    trk_q      <= trk_d;
    sec_q      <= sec_d;
    start_q    <= start_d;
    pend_trk_q <= pend_trk_d;
    res_ok_q   <= res_ok_d;
    res_gt_q   <= res_gt_d;
    res_gs_q   <= res_gs_d;
    if (load_out) begin
      out_ok_q    <= res_ok_q;
      out_gt_q    <= res_gt_q;
      out_gs_q    <= res_gs_q;
      out_total_q <= total_q;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign got_track_o  = out_gt_q;
  assign got_sector_o = out_gs_q;
  assign free_total_o = out_total_q;

  // A row is read or written in a cycle, never both.
  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.rd_en && mem_req_o.wr_en))
    else $error("bitmap read and write in the same cycle");

  // Every write-back follows the read of its row.
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> $past(mem_req_o.rd_en))
    else $error("bitmap write without a preceding read");

  // A pending search row was requested in the previous cycle.
  a_pend_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && pend_q) |-> $past(mem_req_o.rd_en))
    else $error("search checks a row that was not read");

  // Format clears the map only for an accepted request.
  a_clr_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.clr |-> (accept && req_type_i == sba_pkg::REQ_FORMAT))
    else $error("map cleared outside a format request");

  // The result register loads only when it is empty or being drained.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == S_RESP) |=> state_q == S_RESP)
    else $error("result dropped while output stalled");

endmodule

### design/sector_bitmap_allocator.sv
// Top level of the sector bitmap allocator: sequencer and bitmap memory.
// Query, allocate and free: read and check states, then the result register loads.
// Next-free: one candidate track per cycle through the single bitmap read port, each row
//   checked in the cycle after its read.
// Format and rejected: straight to the response state; one request is in flight at a time.
// Reset and format clear the per-row valid bits at once; no clearing pass is needed.
module sector_bitmap_allocator #(
  parameter int unsigned NUM_TRACKS      = 80,
  parameter int unsigned SECTORS_PER_TRK = 40,
  parameter int unsigned RESERVED_TRACK  = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sba_pkg::REQ_W-1:0]   req_type_i,
  input  logic [sba_pkg::TRK_W-1:0]   track_i,
  input  logic [sba_pkg::SEC_W-1:0]   sector_i,
  input  logic [sba_pkg::TRK_W-1:0]   near_track_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [sba_pkg::GT_W-1:0]    got_track_o,
  output logic [sba_pkg::GS_W-1:0]    got_sector_o,
  output logic [sba_pkg::TOT_W-1:0]   free_total_o
);

  localparam int unsigned TW = $clog2(NUM_TRACKS);

  sba_pkg::mem_req_t          mem_req;
  logic [TW-1:0]              rd_addr;
  logic [TW-1:0]              wr_addr;
  logic [SECTORS_PER_TRK-1:0] wr_row;
  logic [SECTORS_PER_TRK-1:0] rd_row;

  sba_ctrl #(
    .NUM_TRACKS      (NUM_TRACKS),
    .SECTORS_PER_TRK (SECTORS_PER_TRK),
    .RESERVED_TRACK  (RESERVED_TRACK),
    .TW              (TW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .track_i      (track_i),
    .sector_i     (sector_i),
    .near_track_i (near_track_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .got_track_o  (got_track_o),
    .got_sector_o (got_sector_o),
    .free_total_o (free_total_o),
    .mem_req_o    (mem_req),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wr_row_o     (wr_row),
    .rd_row_i     (rd_row)
  );

  sba_map_mem #(
    .NUM_TRACKS      (NUM_TRACKS),
    .SECTORS_PER_TRK (SECTORS_PER_TRK),
    .RESERVED_TRACK  (RESERVED_TRACK),
    .TW              (TW)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row),
    .rd_row_o  (rd_row)
  );

endmodule
